// ===== sv/sgab_pkg.sv =====
// Shared types, widths, command structures and arithmetic helpers of the
// stochastic growth integrator. Depends on nothing; every other file uses it.

package sgab_pkg;

  // Fixed number formats.
  localparam int VALUE_W    = 32;  // y, k and slopes, signed Q16.16
  localparam int FRAC_BITS  = 16;
  localparam int NOISE_W    = 16;  // noise sample, signed Q4.12
  localparam int NOISE_FRAC = NOISE_W - 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 31;
  localparam int SIGMA_W    = 31;
  localparam int CORR_W     = 17;
  localparam int GAIN_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MEAN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SIGMA      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRELATION     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INNOVATION_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD          = 3'd6;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd655;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 31'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 31'd65536;
  localparam logic [VALUE_W-1:0] INIT_RESET  = 32'd65536;

  // Datapath widths. The averaged slope needs 35 signed bits, the weighted
  // sum and the rate terms fit in 40, and 52 covers every sum before it is
  // clipped to the value range.
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 40;
  localparam int WIDE_W  = 52;
  localparam int WEIGHT_W = 8;

  // Divide-by-24 unit: eight quotient bits per cycle over a biased dividend.
  localparam int DIV_RADIX = 8;
  localparam int DIV_ITERS = 6;
  localparam int DIV_W     = DIV_RADIX * DIV_ITERS;
  localparam int DIV_CNT_W = 3;
  localparam int REM_W     = 5;

  localparam logic [1:0] STEPS_MAX = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [NOISE_W-1:0] noise_t;

  typedef enum logic [2:0] {
    MUL_CORR_DEV,
    MUL_SIGMA_NOISE,
    MUL_GAIN_NOISE,
    MUL_K_Y,
    MUL_TAP,
    MUL_H_AVG
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_LOAD_P16,
    ACC_ADD_P12,
    ACC_LOAD_P,
    ACC_ADD_P
  } acc_op_e;

  typedef struct packed {
    logic     in_load;       // capture the input word
    logic     init_load;     // load y from the initial value
    logic     mul_en;        // register a new product
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     k_load;        // rate of this step from the accumulator
    logic     f0_load;       // slope of this step from the product
    logic     avg_load;
    logic     avg_from_div;  // averaged slope from the divider, else the slope
    logic     div_start;
    logic [1:0] tap;         // history tap of the weighted sum
    logic [1:0] steps;       // steps taken in this run
    logic     commit;        // write result word and advance the state
  } sgab_cmd_t;

  typedef struct packed {
    logic method;    // 1 selects Adams-Bashforth
    logic div_done;
  } sgab_status_t;

  localparam logic signed [WIDE_W-1:0] WIDE_VMAX =
    {{(WIDE_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_VMIN = ~WIDE_VMAX;

  function automatic value_t sat_value(logic signed [WIDE_W-1:0] x);
    value_t r;
    if (x > WIDE_VMAX) begin
      r = WIDE_VMAX[VALUE_W-1:0];
    end else if (x < WIDE_VMIN) begin
      r = WIDE_VMIN[VALUE_W-1:0];
    end else begin
      r = x[VALUE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic sat_clip(logic signed [WIDE_W-1:0] x);
    return (x > WIDE_VMAX) || (x < WIDE_VMIN);
  endfunction

  // Adams-Bashforth weights over 24, newest slope first.
  function automatic logic signed [WEIGHT_W-1:0] ab_weight(logic [1:0] steps,
                                                          logic [1:0] tap);
    logic signed [WEIGHT_W-1:0] w;
    w = '0;
    case (steps)
      2'd1: begin
        case (tap)
          2'd0:    w = 8'sd36;
          2'd1:    w = -8'sd12;
          default: w = '0;
        endcase
      end
      2'd2: begin
        case (tap)
          2'd0:    w = 8'sd46;
          2'd1:    w = -8'sd32;
          2'd2:    w = 8'sd10;
          default: w = '0;
        endcase
      end
      2'd3: begin
        case (tap)
          2'd0:    w = 8'sd55;
          2'd1:    w = -8'sd59;
          2'd2:    w = 8'sd37;
          default: w = -8'sd9;
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/sgab_stream_if.sv =====
// Valid/ready stream interfaces for the input and result words of the
// integrator. Depends on sgab_pkg for the field widths.

interface sgab_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sgab_pkg::NOISE_W-1:0] noise_sample;
  logic                                start_run;

  modport source (output valid, output noise_sample, output start_run, input ready);
  modport sink   (input valid, input noise_sample, input start_run, output ready);
endinterface

interface sgab_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sgab_pkg::VALUE_W-1:0] next_value;
  logic signed [sgab_pkg::VALUE_W-1:0] rate_value;
  logic                                saturated;

  modport source (output valid, output next_value, output rate_value, output saturated,
                  input ready);
  modport sink   (input valid, input next_value, input rate_value, input saturated,
                  output ready);
endinterface

// ===== sv/sgab_div24.sv =====
// Iterative floor division of the weighted slope sum by 24, eight quotient
// bits per cycle. Depends on sgab_pkg.

module sgab_div24 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [sgab_pkg::ACC_W-1:0]    dividend_i,
  output logic                                 done_o,
  output logic signed [sgab_pkg::MUL_A_W-1:0]  quotient_o
);
  import sgab_pkg::*;

  // A bias of 24 * 2^(ACC_W-1) makes the dividend positive, so a plain
  // restoring division gives the floor; the bias comes off the quotient.
  localparam logic [DIV_W-1:0] DIV_BIAS   = DIV_W'(3) << (ACC_W + 2);
  localparam logic [DIV_W-1:0] QUOT_BIAS  = DIV_W'(1) << (ACC_W - 1);
  localparam logic [REM_W:0]   DIVISOR    = 6'd24;
  localparam logic [DIV_CNT_W-1:0] LAST_ITER = DIV_CNT_W'(DIV_ITERS - 1);

  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_W-1:0]     step_dvd;
  logic [REM_W-1:0]     step_rem;
  logic [DIV_W-1:0]     quot_full;

  always_comb begin
    logic [REM_W:0]   r;
    logic [DIV_W-1:0] d;
    r = {1'b0, rem_q};
    d = dvd_q;
    for (int i = 0; i < DIV_RADIX; i++) begin
      r = {r[REM_W-1:0], d[DIV_W-1]};
      d = {d[DIV_W-2:0], 1'b0};
      if (r >= DIVISOR) begin
        r    = r - DIVISOR;
        d[0] = 1'b1;
      end
    end
    step_dvd = d;
    step_rem = r[REM_W-1:0];
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = {{(DIV_W-ACC_W){dividend_i[ACC_W-1]}}, dividend_i} + DIV_BIAS;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = step_dvd;
      rem_d = step_rem;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_ITER) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign quot_full  = dvd_q - QUOT_BIAS;
  assign quotient_o = quot_full[MUL_A_W-1:0];
  assign done_o     = done_q;

endmodule

// ===== sv/sgab_datapath.sv =====
// Datapath of the integrator: configuration registers, the shared
// multiplier, accumulator, solution state and result register.
// Depends on sgab_pkg and sgab_div24.

module sgab_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sgab_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sgab_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  sgab_pkg::noise_t                     noise_sample_i,
  input  sgab_pkg::sgab_cmd_t                  cmd_i,
  output sgab_pkg::sgab_status_t               status_o,
  output sgab_pkg::value_t                     next_value_o,
  output sgab_pkg::value_t                     rate_value_o,
  output logic                                 saturated_o
);
  import sgab_pkg::*;

  // Configuration registers.
  logic [STEP_W-1:0]  h_q;
  value_t             mean_q;
  logic [SIGMA_W-1:0] sigma_q;
  logic [CORR_W-1:0]  corr_q;
  logic [GAIN_W-1:0]  gain_q;
  value_t             init_q;
  logic               method_q;

  // Run state.
  value_t k_q, k_d;
  value_t y_q;
  value_t hist_q [3];

  // Working registers.
  noise_t                    noise_q;
  logic signed [PROD_W-1:0]  p_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  value_t                    f0_q;
  logic signed [MUL_A_W-1:0] avg_q;
  value_t                    out_next_q, out_rate_q;
  logic                      out_sat_q;

  logic signed [VALUE_W:0]   dev;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  p_s16, p_s12;
  logic signed [WIDE_W-1:0]  k_wide, f0_wide, next_wide;
  value_t                    tap_val;
  logic signed [WEIGHT_W-1:0] weight;
  logic                      div_done;
  logic signed [MUL_A_W-1:0] div_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q      <= STEP_RESET;
      mean_q   <= '0;
      sigma_q  <= SIGMA_RESET;
      corr_q   <= '0;
      gain_q   <= GAIN_RESET;
      init_q   <= INIT_RESET;
      method_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STEP_SIZE:       h_q      <= cfg_data_i[STEP_W-1:0];
        CFG_RATE_MEAN:       mean_q   <= cfg_data_i[VALUE_W-1:0];
        CFG_RATE_SIGMA:      sigma_q  <= cfg_data_i[SIGMA_W-1:0];
        CFG_CORRELATION:     corr_q   <= cfg_data_i[CORR_W-1:0];
        CFG_INNOVATION_GAIN: gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_INITIAL_VALUE:   init_q   <= cfg_data_i[VALUE_W-1:0];
        CFG_METHOD:          method_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Deviation of the previous rate from the mean; k_q still holds the
  // previous rate until this step's rate is loaded.
  assign dev = {k_q[VALUE_W-1], k_q} - {mean_q[VALUE_W-1], mean_q};

  assign weight = ab_weight(cmd_i.steps, cmd_i.tap);

  always_comb begin
    unique case (cmd_i.tap)
      2'd0: tap_val = f0_q;
      2'd1: tap_val = hist_q[0];
      2'd2: tap_val = hist_q[1];
      2'd3: tap_val = hist_q[2];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_CORR_DEV: begin
        mul_a = {{(MUL_A_W-VALUE_W-1){dev[VALUE_W]}}, dev};
        mul_b = {{(MUL_B_W-CORR_W){1'b0}}, corr_q};
      end
      MUL_SIGMA_NOISE: begin
        mul_a = {{(MUL_A_W-NOISE_W){noise_q[NOISE_W-1]}}, noise_q};
        mul_b = {{(MUL_B_W-SIGMA_W){1'b0}}, sigma_q};
      end
      MUL_GAIN_NOISE: begin
        mul_a = {{(MUL_A_W-NOISE_W){noise_q[NOISE_W-1]}}, noise_q};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, gain_q};
      end
      MUL_K_Y: begin
        mul_a = {{(MUL_A_W-VALUE_W){y_q[VALUE_W-1]}}, y_q};
        mul_b = k_q;
      end
      MUL_TAP: begin
        mul_a = {{(MUL_A_W-VALUE_W){tap_val[VALUE_W-1]}}, tap_val};
        mul_b = {{(MUL_B_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
      end
      MUL_H_AVG: begin
        mul_a = avg_q;
        mul_b = {{(MUL_B_W-STEP_W){1'b0}}, h_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign p_s16 = p_q >>> FRAC_BITS;
  assign p_s12 = p_q >>> NOISE_FRAC;

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.acc_op)
      ACC_HOLD:     acc_d = acc_q;
      ACC_CLEAR:    acc_d = '0;
      ACC_LOAD_P16: acc_d = p_s16[ACC_W-1:0];
      ACC_ADD_P12:  acc_d = acc_q + p_s12[ACC_W-1:0];
      ACC_LOAD_P:   acc_d = p_q[ACC_W-1:0];
      ACC_ADD_P:    acc_d = acc_q + p_q[ACC_W-1:0];
      default:      acc_d = acc_q;
    endcase
  end

  assign k_wide = {{(WIDE_W-ACC_W){acc_q[ACC_W-1]}}, acc_q}
                + {{(WIDE_W-VALUE_W){mean_q[VALUE_W-1]}}, mean_q};
  assign k_d    = sat_value(k_wide);

  assign f0_wide   = p_s16[WIDE_W-1:0];
  assign next_wide = {{(WIDE_W-VALUE_W){y_q[VALUE_W-1]}}, y_q} + p_s16[WIDE_W-1:0];

  sgab_div24 u_div24 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      y_q       <= '0;
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
    end else begin
      if (cmd_i.k_load) begin
        k_q <= k_d;
      end
      if (cmd_i.init_load) begin
        y_q <= init_q;
      end else if (cmd_i.commit) begin
        y_q <= sat_value(next_wide);
      end
      if (cmd_i.commit) begin
        hist_q[2] <= hist_q[1];
        hist_q[1] <= hist_q[0];
        hist_q[0] <= f0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      noise_q <= noise_sample_i;
    end
    if (cmd_i.mul_en) begin
      p_q <= prod;
    end
    acc_q <= acc_d;
    if (cmd_i.f0_load) begin
      f0_q <= sat_value(f0_wide);
    end
    if (cmd_i.avg_load) begin
      avg_q <= cmd_i.avg_from_div ? div_quot
                                  : {{(MUL_A_W-VALUE_W){f0_q[VALUE_W-1]}}, f0_q};
    end
    if (cmd_i.commit) begin
      out_next_q <= sat_value(next_wide);
      out_rate_q <= k_q;
      out_sat_q  <= sat_clip(next_wide);
    end
  end

  assign status_o.method   = method_q;
  assign status_o.div_done = div_done;

  assign next_value_o = out_next_q;
  assign rate_value_o = out_rate_q;
  assign saturated_o  = out_sat_q;

endmodule

// ===== sv/sgab_ctrl.sv =====
// Sequencer of the integrator: walks one word through rate, slope,
// weighted history and division (Adams-Bashforth steps with history only) and
// increment, and owns the handshakes. Depends on sgab_pkg.

module sgab_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_start_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  sgab_pkg::sgab_status_t status_i,
  output sgab_pkg::sgab_cmd_t    cmd_o
);
  import sgab_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_RATE_DEV   = 14'b00000000000010,
    S_RATE_NOISE = 14'b00000000000100,
    S_RATE_SUM   = 14'b00000000001000,
    S_RATE_K     = 14'b00000000010000,
    S_SLOPE_MUL  = 14'b00000000100000,
    S_SLOPE_SAT  = 14'b00000001000000,
    S_EULER_AVG  = 14'b00000010000000,
    S_TAP        = 14'b00000100000000,
    S_TAP_END    = 14'b00001000000000,
    S_DIV_START  = 14'b00010000000000,
    S_DIV        = 14'b00100000000000,
    S_INC_MUL    = 14'b01000000000000,
    S_FINISH     = 14'b10000000000000
  } state_e;

  state_e     state_q, state_d;
  logic       start_q, start_d;
  logic [1:0] steps_q, steps_d;
  logic [1:0] tap_q, tap_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    steps_d     = steps_q;
    tap_d       = tap_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o              = '0;
    cmd_o.mul_sel      = MUL_CORR_DEV;
    cmd_o.acc_op       = ACC_HOLD;
    cmd_o.tap          = tap_q;
    cmd_o.steps        = steps_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.in_load   = 1'b1;
          cmd_o.init_load = in_start_i;
          start_d         = in_start_i;
          if (in_start_i) begin
            steps_d = '0;
            state_d = S_RATE_NOISE;
          end else begin
            state_d = S_RATE_DEV;
          end
        end
      end
      S_RATE_DEV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CORR_DEV;
        state_d       = S_RATE_NOISE;
      end
      S_RATE_NOISE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = start_q ? MUL_SIGMA_NOISE : MUL_GAIN_NOISE;
        cmd_o.acc_op  = start_q ? ACC_CLEAR : ACC_LOAD_P16;
        state_d       = S_RATE_SUM;
      end
      S_RATE_SUM: begin
        cmd_o.acc_op = ACC_ADD_P12;
        state_d      = S_RATE_K;
      end
      S_RATE_K: begin
        cmd_o.k_load = 1'b1;
        state_d      = S_SLOPE_MUL;
      end
      S_SLOPE_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_K_Y;
        state_d       = S_SLOPE_SAT;
      end
      S_SLOPE_SAT: begin
        cmd_o.f0_load = 1'b1;
        if (!status_i.method || steps_q == 2'd0) begin
          state_d = S_EULER_AVG;
        end else begin
          tap_d   = '0;
          state_d = S_TAP;
        end
      end
      // The Euler path takes the averaged slope straight from the slope
      // register, in the cycle after that register is loaded.
      S_EULER_AVG: begin
        cmd_o.avg_load = 1'b1;
        state_d        = S_INC_MUL;
      end
      S_TAP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TAP;
        priority if (tap_q == 2'd0) begin
          cmd_o.acc_op = ACC_HOLD;
        end else if (tap_q == 2'd1) begin
          cmd_o.acc_op = ACC_LOAD_P;
        end else begin
          cmd_o.acc_op = ACC_ADD_P;
        end
        if (tap_q == steps_q) begin
          state_d = S_TAP_END;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      S_TAP_END: begin
        cmd_o.acc_op = ACC_ADD_P;
        state_d      = S_DIV_START;
      end
      S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.avg_load     = 1'b1;
          cmd_o.avg_from_div = 1'b1;
          state_d            = S_INC_MUL;
        end
      end
      S_INC_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_H_AVG;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          steps_d      = (steps_q == STEPS_MAX) ? STEPS_MAX : steps_q + 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      steps_q     <= '0;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      steps_q     <= steps_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/stochastic_growth_ab4_integrator.sv =====
// Top level of the stochastic growth integrator: ties the sequencer and the
// datapath to the two word streams and the configuration port.
// Depends on sgab_pkg, sgab_stream_if, sgab_ctrl and sgab_datapath.
//
//   Channel  | Direction | Contents                                  | Handshake
//   ---------+-----------+-------------------------------------------+-------------
//   in_if    | sink      | noise_sample (Q4.12), start_run           | valid/ready
//   out_if   | source    | next_value, rate_value (Q16.16), saturated| valid/ready
//   cfg      | sink      | cfg_we_i, cfg_index_i, cfg_data_i         | write enable
//
// One word is in work at a time. An Euler step (and the first step of a run)
// goes through rate, slope and increment, and a word that starts a run skips
// the deviation product; an Adams-Bashforth step with n steps of history,
// n from 1 to 3, adds a product for each weighted slope and the division.
// The single shared 35 x 32 multiplier carries every product of the step in
// turn, and the divide-by-24 unit retires eight quotient bits per cycle.
// Reset clears the run state: previous rate, y, slope history and step count.
// A finished word waits in the output register; the next word is accepted
// meanwhile and stalls in its last cycle until the register is free.

module stochastic_growth_ab4_integrator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sgab_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sgab_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sgab_in_if.sink                         in_if,
  sgab_out_if.source                      out_if
);
  import sgab_pkg::*;

  sgab_cmd_t    cmd;
  sgab_status_t status;
  value_t       next_value;
  value_t       rate_value;
  logic         saturated;
  logic         in_ready;
  logic         out_valid;

  // The sequencer steps each word through rate, slope, optional weighted
  // history with division, increment, and the result write.
  sgab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_start_i  (in_if.start_run),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the run state and the result
  // register, and does all arithmetic under the sequencer's commands.
  sgab_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .noise_sample_i (in_if.noise_sample),
    .cmd_i          (cmd),
    .status_o       (status),
    .next_value_o   (next_value),
    .rate_value_o   (rate_value),
    .saturated_o    (saturated)
  );

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid;
  assign out_if.next_value = next_value;
  assign out_if.rate_value = rate_value;
  assign out_if.saturated  = saturated;

endmodule

// ===== sv/sgab_checker.sv =====
// Port-level checks of the integrator's word streams, attached to the top
// level by the bind statement at the end. Depends on sgab_pkg.

module sgab_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  sgab_pkg::value_t next_value_i,
  input  sgab_pkg::value_t rate_value_i,
  input  logic             saturated_i
);
  import sgab_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Words accepted whose result word has not yet been taken.
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A result word, once offered, stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word withdrawn before it was taken");

  // A stalled result word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(next_value_i) && $stable(rate_value_i) && $stable(saturated_i))
    else $error("stalled result word changed");

  // Only one word is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input accepted again while a word is in work");

  // Every result word answers an accepted input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result word without an accepted input word");

  // At most one word in work plus one waiting in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words outstanding");

endmodule

bind stochastic_growth_ab4_integrator sgab_checker u_sgab_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .next_value_i (out_if.next_value),
  .rate_value_i (out_if.rate_value),
  .saturated_i  (out_if.saturated)
);

// ===== tb/sv/tb_stochastic_growth_ab4_integrator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the stochastic growth integrator: a directed table
// and random runs, each result checked against an in-bench fixed-point model.
// Depends on sgab_pkg, the stream interfaces and the integrator top level.

module tb_stochastic_growth_ab4_integrator;
  import sgab_pkg::*;

  // The spare index lies past the last register and must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

  // Run length in words and timing limits in clock cycles.
  localparam int RANDOM_WORDS     = 1230;
  localparam int SETTLE_CYCLES    = 32;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 5000;

  // Fixed-point limits of the model.
  localparam longint WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam longint LONG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LONG_MIN = -LONG_MAX - 1;

  // Step weights over a common denominator of 24, newest slope first.
  localparam longint SLOPE_DENOM = 24;
  localparam longint AB2_W0 = 36;
  localparam longint AB2_W1 = -12;
  localparam longint AB3_W0 = 46;
  localparam longint AB3_W1 = -32;
  localparam longint AB3_W2 = 10;
  localparam longint AB4_W0 = 55;
  localparam longint AB4_W1 = -59;
  localparam longint AB4_W2 = 37;
  localparam longint AB4_W3 = -9;

  typedef struct packed {
    value_t next_value;
    value_t rate_value;
    logic   saturated;
  } step_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    noise_t                noise;
    logic                  start;
    bit                    typed;   // the expected result is given in the row
    step_result_t          want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sgab_in_if  in_if ();
  sgab_out_if out_if ();

  stochastic_growth_ab4_integrator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model copy of the registers and of the run state.
  longint model_step, model_mean, model_sigma, model_corr, model_gain, model_init;
  bit     model_method;
  longint model_rate, model_value;
  longint model_slopes [3];
  int     model_steps;
  bit     step_clipped;

  // Results predicted for accepted words, oldest first.
  step_result_t pending_steps [$];
  stim_row_t    directed_rows [$];

  // Idle behavior of both sides: 0 never idles, 1 short gaps, 2 short and long gaps.
  int tx_mode = 1;
  int rx_mode = 1;
  bit hold_request = 1'b0;

  int error_count     = 0;
  int words_sent      = 0;
  int runs_started    = 0;
  int ab_steps        = 0;
  int writes_done     = 0;
  int results_checked = 0;
  int clipped_results = 0;
  int holds_done      = 0;
  int stall_cycles    = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point model. Products are exact and floored; every intermediate is
  // clipped to 64 bits, rate, slope and y to the word range. Only clipping of
  // the weighted sum, the increment and the new y shows on the saturated flag.
  // ---------------------------------------------------------------------------
  function automatic longint clip_long(logic signed [129:0] x, bit track);
    if (x > LONG_MAX) begin
      if (track) step_clipped = 1'b1;
      return LONG_MAX;
    end
    if (x < LONG_MIN) begin
      if (track) step_clipped = 1'b1;
      return LONG_MIN;
    end
    return x[63:0];
  endfunction

  function automatic longint mul_floor(longint a, longint b, int sh, bit track);
    logic signed [129:0] wa, wb;
    wa = a;
    wb = b;
    return clip_long((wa * wb) >>> sh, track);
  endfunction

  function automatic longint add_clip(longint a, longint b, bit track);
    logic signed [129:0] s;
    s = a;
    s = s + b;
    return clip_long(s, track);
  endfunction

  function automatic longint clip_word(longint x, bit track);
    if (x > WORD_MAX) begin
      if (track) step_clipped = 1'b1;
      return WORD_MAX;
    end
    if (x < WORD_MIN) begin
      if (track) step_clipped = 1'b1;
      return WORD_MIN;
    end
    return x;
  endfunction

  // Division by 24 that rounds toward minus infinity.
  function automatic longint floor_div24(longint w);
    if (w >= 0) return w / SLOPE_DENOM;
    return -((-(w + 1)) / SLOPE_DENOM) - 1;
  endfunction

  function automatic step_result_t integrate_step(noise_t noise, logic start);
    longint nz, y, k, f0, avg, wsum, inc, nxt, t, dev;
    step_result_t r;
    step_clipped = 1'b0;
    nz = noise;
    if (start) begin
      // A new run restarts from the initial value with the first-rate rule.
      y = clip_word(model_init, 1'b0);
      model_steps = 0;
      t = mul_floor(model_sigma, nz, NOISE_FRAC, 1'b0);
      k = clip_word(add_clip(model_mean, t, 1'b0), 1'b0);
    end else begin
      // Correlated rate: C*(k_prev - mean) + gain*noise + mean.
      dev = add_clip(model_rate, -model_mean - 1, 1'b0);
      dev = add_clip(dev, 1, 1'b0);
      y = model_value;
      t = mul_floor(model_corr, dev, FRAC_BITS, 1'b0);
      t = add_clip(t, mul_floor(model_gain, nz, NOISE_FRAC, 1'b0), 1'b0);
      k = clip_word(add_clip(t, model_mean, 1'b0), 1'b0);
    end
    f0 = clip_word(mul_floor(k, y, FRAC_BITS, 1'b0), 1'b0);
    if (!model_method || model_steps == 0) begin
      avg = f0;
    end else begin
      ab_steps++;
      case (model_steps)
        1: begin
          wsum = add_clip(mul_floor(f0, AB2_W0, 0, 1'b1),
                          mul_floor(model_slopes[0], AB2_W1, 0, 1'b1), 1'b1);
        end
        2: begin
          wsum = add_clip(mul_floor(f0, AB3_W0, 0, 1'b1),
                          mul_floor(model_slopes[0], AB3_W1, 0, 1'b1), 1'b1);
          wsum = add_clip(wsum, mul_floor(model_slopes[1], AB3_W2, 0, 1'b1), 1'b1);
        end
        default: begin
          wsum = add_clip(mul_floor(f0, AB4_W0, 0, 1'b1),
                          mul_floor(model_slopes[0], AB4_W1, 0, 1'b1), 1'b1);
          wsum = add_clip(wsum, mul_floor(model_slopes[1], AB4_W2, 0, 1'b1), 1'b1);
          wsum = add_clip(wsum, mul_floor(model_slopes[2], AB4_W3, 0, 1'b1), 1'b1);
        end
      endcase
      avg = floor_div24(wsum);
    end
    inc = mul_floor(model_step, avg, FRAC_BITS, 1'b1);
    nxt = clip_word(add_clip(y, inc, 1'b1), 1'b1);
    // The history is kept in both methods, so a method change acts at once.
    model_slopes[2] = model_slopes[1];
    model_slopes[1] = model_slopes[0];
    model_slopes[0] = f0;
    if (model_steps < 3) model_steps++;
    model_rate  = k;
    model_value = nxt;
    r.next_value = nxt[VALUE_W-1:0];
    r.rate_value = k[VALUE_W-1:0];
    r.saturated  = step_clipped;
    return r;
  endfunction

  task automatic reset_model();
    model_step   = STEP_RESET;
    model_mean   = 0;
    model_sigma  = SIGMA_RESET;
    model_corr   = 0;
    model_gain   = GAIN_RESET;
    model_init   = $signed(INIT_RESET);
    model_method = 1'b0;
    model_rate   = 0;
    model_value  = 0;
    model_slopes[0] = 0;
    model_slopes[1] = 0;
    model_slopes[2] = 0;
    model_steps  = 0;
  endtask

  // Registers keep only their own width; unknown indexes change nothing.
  task automatic load_model_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_STEP_SIZE:       model_step   = data[STEP_W-1:0];
      CFG_RATE_MEAN:       model_mean   = $signed(data);
      CFG_RATE_SIGMA:      model_sigma  = data[SIGMA_W-1:0];
      CFG_CORRELATION:     model_corr   = data[CORR_W-1:0];
      CFG_INNOVATION_GAIN: model_gain   = data[GAIN_W-1:0];
      CFG_INITIAL_VALUE:   model_init   = $signed(data);
      CFG_METHOD:          model_method = data[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving. Every input changes with a nonblocking assignment at a rising
  // edge, and a word counts as accepted at the edge where valid and ready are
  // both seen high.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, (mode == 2) ? 60 : 20);
  endfunction

  task automatic send_word(noise_t noise, logic start, bit typed, step_result_t want);
    int gap;
    step_result_t predicted;
    gap = pick_gap(tx_mode);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.noise_sample <= noise;
    in_if.start_run    <= start;
    do @(posedge clk_i); while (!in_if.ready);
    // The model always advances; a typed row replaces only the expectation.
    predicted = integrate_step(noise, start);
    pending_steps.push_back(typed ? want : predicted);
    words_sent++;
    if (start) runs_started++;
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
  endtask

  // Registers may change only while the block is idle.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    load_model_register(index, data);
    writes_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed result run from the reset settings,
  // where the answer is plain; the rest are checked against the model.
  // ---------------------------------------------------------------------------
  task automatic add_word(noise_t noise, logic start);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WORD;
    row.noise = noise;
    row.start = start;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(noise_t noise, logic start, value_t next_value,
                           value_t rate_value, logic saturated);
    stim_row_t row;
    row                 = '0;
    row.kind            = ROW_WORD;
    row.noise           = noise;
    row.start           = start;
    row.typed           = 1'b1;
    row.want.next_value = next_value;
    row.want.rate_value = rate_value;
    row.want.saturated  = saturated;
    directed_rows.push_back(row);
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = index;
    row.data  = data;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_table();
    // Before any run is started y stays zero; with no correlation the rate
    // is just the noise scaled by the unit gain.
    add_typed(16'sd0, 1'b0, 32'sd0, 32'sd0, 1'b0);
    add_typed(16'sh7FFF, 1'b0, 32'sd0, 32'sd524272, 1'b0);
    add_typed(16'sh8000, 1'b0, 32'sd0, -32'sd524288, 1'b0);
    // A run starts from the initial value 1.0 with a zero rate.
    add_typed(16'sd0, 1'b1, 32'sd65536, 32'sd0, 1'b0);
    add_word(16'sd4096, 1'b0);
    add_word(-16'sd4096, 1'b0);
    add_word(16'sd2048, 1'b0);
    // Adams-Bashforth: an Euler step first, then the bootstrap steps and the
    // full four-step formula.
    add_write(CFG_METHOD, 32'd1);
    add_word(16'sd4096, 1'b1);
    add_word(16'sd1000, 1'b0);
    add_word(-16'sd3000, 1'b0);
    add_word(16'sd500, 1'b0);
    add_word(16'sd7000, 1'b0);
    // Switching the method in mid-run keeps the slope history.
    add_write(CFG_METHOD, 32'd0);
    add_word(16'sd100, 1'b0);
    add_write(CFG_METHOD, 32'd1);
    add_word(-16'sd200, 1'b0);
    // A correlation written above 1.0 is kept to its width and used as it is.
    add_write(CFG_CORRELATION, 32'hFFFF_FFFF);
    add_write(CFG_INNOVATION_GAIN, 32'h0000_8000);
    add_word(16'sd300, 1'b0);
    add_word(-16'sd300, 1'b0);
    // Top extremes: the rate clips silently, y clips and flags it.
    add_write(CFG_RATE_MEAN, 32'h7FFF_FFFF);
    add_write(CFG_RATE_SIGMA, 32'hFFFF_FFFF);
    add_write(CFG_INITIAL_VALUE, 32'h7FFF_FFFF);
    add_write(CFG_STEP_SIZE, 32'hFFFF_FFFF);
    add_word(16'sh7FFF, 1'b1);
    add_word(16'sh7FFF, 1'b0);
    // Bottom extremes of the signed registers and of the noise.
    add_write(CFG_RATE_MEAN, 32'h8000_0000);
    add_write(CFG_INITIAL_VALUE, 32'h8000_0000);
    add_word(16'sh8000, 1'b1);
    add_word(16'sh8000, 1'b0);
    // A zero step size freezes y.
    add_write(CFG_STEP_SIZE, 32'd0);
    add_word(16'sd1234, 1'b0);
    // A write to the index past the register list must change nothing.
    add_write(CFG_SPARE_INDEX, 32'hFFFF_FFFF);
    add_word(16'sd5, 1'b0);
  endtask

  task automatic run_directed();
    bit writing;
    stim_row_t row;
    writing = 1'b0;
    build_directed_table();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!writing) begin
          settle();
          writing = 1'b1;
        end
        write_register(row.index, row.data);
      end else begin
        if (writing) begin
          cfg_we_i <= 1'b0;
          writing = 1'b0;
        end
        send_word(row.noise, row.start, row.typed, row.want);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random part: phases of a new register setting followed by runs of words.
  // ---------------------------------------------------------------------------
  function automatic logic [CFG_DATA_W-1:0] pick_register_value(logic [CFG_IDX_W-1:0] index);
    logic [CFG_DATA_W-1:0] v;
    int flavor;
    flavor = $urandom_range(0, 19);
    if (flavor == 0) begin
      v = '0;
    end else if (flavor == 1) begin
      v = '1;
    end else if (flavor == 2) begin
      v = $urandom();
    end else begin
      // Moderate settings keep most runs away from the clipping limits.
      case (index)
        CFG_STEP_SIZE:       v = $urandom_range(1, 13107);
        CFG_RATE_MEAN:       v = $urandom_range(0, 131072) - 65536;
        CFG_RATE_SIGMA:      v = $urandom_range(0, 131072);
        CFG_CORRELATION:     v = $urandom_range(0, 65536);
        CFG_INNOVATION_GAIN: v = $urandom_range(0, 65536);
        CFG_INITIAL_VALUE:   v = $urandom_range(0, 524288) - 262144;
        default:             v = $urandom();
      endcase
    end
    return v;
  endfunction

  task automatic randomize_registers();
    write_register(CFG_STEP_SIZE, pick_register_value(CFG_STEP_SIZE));
    write_register(CFG_RATE_MEAN, pick_register_value(CFG_RATE_MEAN));
    write_register(CFG_RATE_SIGMA, pick_register_value(CFG_RATE_SIGMA));
    write_register(CFG_CORRELATION, pick_register_value(CFG_CORRELATION));
    write_register(CFG_INNOVATION_GAIN, pick_register_value(CFG_INNOVATION_GAIN));
    write_register(CFG_INITIAL_VALUE, pick_register_value(CFG_INITIAL_VALUE));
    write_register(CFG_METHOD, pick_register_value(CFG_METHOD));
    if ($urandom_range(0, 3) == 0) write_register(CFG_SPARE_INDEX, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_word(bit first);
    noise_t noise;
    logic start;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      if ($urandom_range(0, 1) != 0) noise = 16'sh7FFF;
      else noise = 16'sh8000;
    end else if (r < 5) begin
      noise = noise_t'($urandom_range(0, 65535));
    end else begin
      noise = noise_t'($urandom_range(0, 16384) - 8192);
    end
    // Most phases open with a run start, and runs last a couple of dozen words.
    if (first) start = ($urandom_range(0, 3) != 0);
    else start = ($urandom_range(0, 23) == 0);
    send_word(noise, start, 1'b0, '0);
  endtask

  task automatic run_random_phases();
    int phase, count, sent;
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      randomize_registers();
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      // In hold phases the sender keeps offering so that the block backs up.
      if (phase % 3 == 1) tx_mode = 0;
      count = $urandom_range(60, 150);
      for (int i = 0; i < count && sent < RANDOM_WORDS; i++) begin
        if (i == count / 2 && phase % 3 == 1) hold_request = 1'b1;
        if (i == count / 2 && phase % 3 == 2) drain_results();
        send_random_word(i == 0);
        sent++;
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls at random, and on request holds ready
  // low for a long stretch; the checker compares each word with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int hold;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end else begin
        hold = pick_gap(rx_mode);
      end
      out_if.ready <= (hold == 0);
      repeat ((hold == 0) ? 1 : hold) @(posedge clk_i);
    end
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("Mismatch in %s of result %0d: got %0d, expected %0d",
             field, results_checked, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin : result_checker
    step_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_steps.size() == 0) begin
        $display("Unexpected result word: next_value %0d, rate_value %0d",
                 out_if.next_value, out_if.rate_value);
        error_count++;
      end else begin
        want = pending_steps.pop_front();
        if (out_if.next_value !== want.next_value)
          report_mismatch("next_value", out_if.next_value, want.next_value);
        if (out_if.rate_value !== want.rate_value)
          report_mismatch("rate_value", out_if.rate_value, want.rate_value);
        if (out_if.saturated !== want.saturated)
          report_mismatch("saturated", out_if.saturated, want.saturated);
        if (want.saturated) clipped_results++;
      end
      results_checked++;
    end
  end

  // Counts cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("No word moved for %0d cycles, %0d results still pending",
             WATCHDOG_LIMIT, pending_steps.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, final drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.noise_sample = '0;
    in_if.start_run    = 1'b0;
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random_phases();
    settle();

    if (pending_steps.size() != 0) begin
      $display("%0d predicted results never arrived", pending_steps.size());
      error_count++;
    end
    $display("Covered %0d words in %0d runs, %0d of them Adams-Bashforth steps, %0d writes",
             words_sent, runs_started, ab_steps, writes_done);
    $display("Checked %0d results, %0d clipped, %0d long receiver holds, %0d mismatches",
             results_checked, clipped_results, holds_done, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sgab_pkg.sv
sv/sgab_stream_if.sv
sv/sgab_div24.sv
sv/sgab_datapath.sv
sv/sgab_ctrl.sv
sv/stochastic_growth_ab4_integrator.sv
sv/sgab_checker.sv
tb/sv/tb_stochastic_growth_ab4_integrator.sv
